>>> sv/crtc_pkg.sv
// Shared types, codes and constants for the CRT controller raster timing unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
package crtc_pkg;

  // Kind of request on the input channel
  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // Port numbers (low nibble of the I/O address)
  localparam logic [3:0] PORT_INDEX  = 4'd4;
  localparam logic [3:0] PORT_DATA   = 4'd5;
  localparam logic [3:0] PORT_STATUS = 4'd10;

  // Register file
  localparam int NREGS = 18;
  localparam int REG_IDX_W = 5;

  localparam logic [REG_IDX_W-1:0] R_HDISP     = 5'd1;
  localparam logic [REG_IDX_W-1:0] R_SYNC_W    = 5'd3;
  localparam logic [REG_IDX_W-1:0] R_VTOTAL    = 5'd4;
  localparam logic [REG_IDX_W-1:0] R_VADJ      = 5'd5;
  localparam logic [REG_IDX_W-1:0] R_VDISP     = 5'd6;
  localparam logic [REG_IDX_W-1:0] R_VSYNC_POS = 5'd7;
  localparam logic [REG_IDX_W-1:0] R_MODE      = 5'd8;
  localparam logic [REG_IDX_W-1:0] R_MAXSCAN   = 5'd9;
  localparam logic [REG_IDX_W-1:0] R_CUR_START = 5'd10;
  localparam logic [REG_IDX_W-1:0] R_CUR_END   = 5'd11;
  localparam logic [REG_IDX_W-1:0] R_START_HI  = 5'd12;
  localparam logic [REG_IDX_W-1:0] R_START_LO  = 5'd13;

  // Output raster line counter wraps here
  localparam int LINE_WRAP = 720;

  // Status bits
  localparam int ST_DISP_OFF = 0;
  localparam int ST_VSYNC    = 3;

  // Writable bits of each register; out-of-range index writes nothing
  function automatic logic [7:0] reg_mask(input logic [REG_IDX_W-1:0] idx);
    logic [7:0] m;
    case (idx)
      5'd4, 5'd6, 5'd7, 5'd10: m = 8'h7f;
      5'd5, 5'd9, 5'd11:       m = 8'h1f;
      5'd8:                    m = 8'hf3;
      5'd12, 5'd14:            m = 8'h3f;
      5'd0, 5'd1, 5'd2, 5'd3,
      5'd13, 5'd15, 5'd16,
      5'd17:                   m = 8'hff;
      default:                 m = 8'h00;
    endcase
    return m;
  endfunction

  // Register values the raster logic looks at
  typedef struct packed {
    logic [7:0] hdisp;
    logic [7:0] sync_w;
    logic [7:0] vtotal;
    logic [7:0] vadj;
    logic [7:0] vdisp;
    logic [7:0] vsync_pos;
    logic [7:0] mode;
    logic [7:0] maxscan;
    logic [7:0] cur_start;
    logic [7:0] cur_end;
    logic [7:0] start_hi;
    logic [7:0] start_lo;
  } timing_regs_t;

  // Raster state as shown in a result
  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] row_address;
    logic [4:0]  scan_line;
    logic [6:0]  row_count;
    logic        display_enable;
    logic        cursor_visible;
    logic        line_half;
    logic [9:0]  display_line;
  } raster_view_t;

endpackage

>>> sv/crtc_regfile.sv
// CRTC register file: index register, masked register writes and port reads.
// Depends on crtc_pkg.
`timescale 1ns / 1ps
module crtc_regfile (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  commit,
  input  crtc_pkg::action_t     action,
  input  logic [3:0]            port,
  input  logic [7:0]            data,
  input  logic [3:0]            status_cur,
  output crtc_pkg::timing_regs_t tregs,
  output logic [7:0]            read_data
);
  import crtc_pkg::*;

  logic [7:0]           regs_r [NREGS];
  logic [REG_IDX_W-1:0] index_r;
  logic                 index_ok;

  assign index_ok = ({27'd0, index_r} < NREGS);

  // Index and register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r <= '0;
      for (int i = 0; i < NREGS; i++) regs_r[i] <= '0;
    end else if (commit && action == ACT_WRITE) begin
      if (port == PORT_INDEX) begin
        index_r <= data[REG_IDX_W-1:0];
      end else if (port == PORT_DATA && index_ok) begin
        regs_r[index_r] <= data & reg_mask(index_r);
      end
    end
  end

  // Port read mux; only reads return data
  always_comb begin
    read_data = 8'h00;
    if (action == ACT_READ) begin
      case (port)
        PORT_INDEX:  read_data = {3'd0, index_r};
        PORT_DATA:   read_data = index_ok ? regs_r[index_r] : 8'h00;
        PORT_STATUS: read_data = {4'd0, status_cur};
        default:     read_data = 8'hff;
      endcase
    end
  end

  // Fixed taps for the raster logic
  assign tregs.hdisp     = regs_r[R_HDISP];
  assign tregs.sync_w    = regs_r[R_SYNC_W];
  assign tregs.vtotal    = regs_r[R_VTOTAL];
  assign tregs.vadj      = regs_r[R_VADJ];
  assign tregs.vdisp     = regs_r[R_VDISP];
  assign tregs.vsync_pos = regs_r[R_VSYNC_POS];
  assign tregs.mode      = regs_r[R_MODE];
  assign tregs.maxscan   = regs_r[R_MAXSCAN];
  assign tregs.cur_start = regs_r[R_CUR_START];
  assign tregs.cur_end   = regs_r[R_CUR_END];
  assign tregs.start_hi  = regs_r[R_START_HI];
  assign tregs.start_lo  = regs_r[R_START_LO];

endmodule

>>> sv/crtc_raster.sv
// CRTC raster counters: half-line tick handling for address, scanline, rows,
// vertical adjust, vsync, cursor and blink. Depends on crtc_pkg.
`timescale 1ns / 1ps
module crtc_raster (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tick,
  input  crtc_pkg::timing_regs_t tregs,
  output logic [3:0]             status_cur,
  output crtc_pkg::raster_view_t view_nxt
);
  import crtc_pkg::*;

  logic        half_r, half_nxt;
  logic        dbl_r, dbl_nxt;
  logic [4:0]  scan_r, scan_nxt;
  logic [6:0]  row_r, row_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] rstart_r, rstart_nxt;
  logic [4:0]  adj_r, adj_nxt;
  logic [4:0]  vs_r, vs_nxt;
  logic        cwin_r, cwin_nxt;
  logic        blon_r, blon_nxt;
  logic [4:0]  blink_r, blink_nxt;
  logic        disp_r, disp_nxt;
  logic [3:0]  st_r, st_nxt;
  logic [9:0]  line_r, line_nxt;

  logic        dscan;
  logic [15:0] start_addr;
  logic [10:0] line_inc;
  logic [4:0]  vs_dec;

  // Scanline compare, also matching half the value in double-scan mode
  function automatic logic scan_match(input logic [4:0] sc, input logic [4:0] v,
                                      input logic ds);
    return (sc == v) || (ds && sc == {1'b0, v[4:1]});
  endfunction

  assign dscan      = (tregs.mode[1:0] == 2'b11);
  assign start_addr = {2'b00, tregs.start_hi[5:0], tregs.start_lo};
  assign line_inc   = {1'b0, line_r} + 11'd1;
  assign vs_dec     = vs_r - 5'd1;

  // Next raster state for a tick
  always_comb begin
    half_nxt   = half_r;
    dbl_nxt    = dbl_r;
    scan_nxt   = scan_r;
    row_nxt    = row_r;
    addr_nxt   = addr_r;
    rstart_nxt = rstart_r;
    adj_nxt    = adj_r;
    vs_nxt     = vs_r;
    cwin_nxt   = cwin_r;
    blon_nxt   = blon_r;
    blink_nxt  = blink_r;
    disp_nxt   = disp_r;
    st_nxt     = st_r;
    line_nxt   = line_r;
    if (tick && !half_r) begin
      // first half-line
      st_nxt[ST_DISP_OFF] = 1'b1;
      half_nxt = 1'b1;
      if (disp_r) addr_nxt = addr_r + {8'd0, tregs.hdisp};
      if ({1'b0, row_r} == tregs.vsync_pos && scan_r == 5'd0) st_nxt[ST_VSYNC] = 1'b1;
      line_nxt = (line_inc >= 11'(LINE_WRAP)) ? 10'd0 : line_inc[9:0];
    end else if (tick) begin
      // second half-line
      if (disp_r) st_nxt[ST_DISP_OFF] = 1'b0;
      half_nxt = 1'b0;
      dbl_nxt  = ~dbl_r;
      if (!dbl_r) begin
        // first of the doubled pair: rescan the same row
        addr_nxt = rstart_r;
      end else begin
        if (vs_r != 5'd0) begin
          vs_nxt = vs_dec;
          if (vs_dec == 5'd0) st_nxt[ST_VSYNC] = 1'b0;
        end
        if (scan_match(scan_r, tregs.cur_end[4:0], dscan)) cwin_nxt = 1'b0;
        if (adj_r != 5'd0) begin
          // vertical adjust lines
          scan_nxt = scan_r + 5'd1;
          addr_nxt = rstart_r;
          adj_nxt  = adj_r - 5'd1;
          if (adj_r == 5'd1) begin
            disp_nxt   = 1'b1;
            addr_nxt   = start_addr;
            rstart_nxt = start_addr;
            scan_nxt   = 5'd0;
          end
        end else if (scan_match(scan_r, tregs.maxscan[4:0], dscan)) begin
          // end of character row
          rstart_nxt = addr_r;
          scan_nxt   = 5'd0;
          row_nxt    = row_r + 7'd1;
          if ({1'b0, row_nxt} == tregs.vdisp) disp_nxt = 1'b0;
          if ({1'b0, row_r} == tregs.vtotal) begin
            row_nxt = 7'd0;
            adj_nxt = tregs.vadj[4:0];
            if (tregs.vadj[4:0] == 5'd0) begin
              disp_nxt   = 1'b1;
              addr_nxt   = start_addr;
              rstart_nxt = start_addr;
            end
            blon_nxt = (tregs.cur_start[6:5] == 2'b01) ? 1'b0 : blink_r[4];
          end
          if ({1'b0, row_nxt} == tregs.vsync_pos) begin
            disp_nxt  = 1'b0;
            line_nxt  = 10'd0;
            vs_nxt    = {1'b0, tregs.sync_w[7:4]} + 5'd1;
            blink_nxt = blink_r + 5'd1;
          end
        end else begin
          scan_nxt = scan_r + 5'd1;
          addr_nxt = rstart_r;
        end
        if (scan_match(scan_nxt, tregs.cur_start[4:0], dscan)) cwin_nxt = 1'b1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r   <= 1'b0;
      dbl_r    <= 1'b0;
      scan_r   <= '0;
      row_r    <= '0;
      addr_r   <= '0;
      rstart_r <= '0;
      adj_r    <= '0;
      vs_r     <= '0;
      cwin_r   <= 1'b0;
      blon_r   <= 1'b0;
      blink_r  <= '0;
      disp_r   <= 1'b0;
      st_r     <= '0;
      line_r   <= '0;
    end else begin
      half_r   <= half_nxt;
      dbl_r    <= dbl_nxt;
      scan_r   <= scan_nxt;
      row_r    <= row_nxt;
      addr_r   <= addr_nxt;
      rstart_r <= rstart_nxt;
      adj_r    <= adj_nxt;
      vs_r     <= vs_nxt;
      cwin_r   <= cwin_nxt;
      blon_r   <= blon_nxt;
      blink_r  <= blink_nxt;
      disp_r   <= disp_nxt;
      st_r     <= st_nxt;
      line_r   <= line_nxt;
    end
  end

  assign status_cur = st_r;

  // State after this request, for the result
  assign view_nxt.status         = st_nxt;
  assign view_nxt.row_address    = addr_nxt;
  assign view_nxt.scan_line      = scan_nxt;
  assign view_nxt.row_count      = row_nxt;
  assign view_nxt.display_enable = disp_nxt;
  assign view_nxt.cursor_visible = cwin_nxt & blon_nxt;
  assign view_nxt.line_half      = dbl_nxt;
  assign view_nxt.display_line   = line_nxt;

endmodule

>>> sv/crt_controller_raster_timing_unit.sv
// Top level of the CRT controller raster timing unit: input register,
// register file, raster counters and result register. Depends on crtc_pkg.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | action, port, data
//   out_    | output    | out_valid/out_stall| read_data, status, row_address,
//           |           |                    | scan_line, row_count, flags,
//           |           |                    | display_line
//
// One request per clock while out_stall is low: a request is held in the input
// register and resolved into the result register once that one is free.
// The counter update of a tick is the longest path (one 16-bit add plus compares).
// Reset (rst_n low, synchronous) empties both stages, clears regfile and counters.
// With out_stall high and a result waiting, the input register holds its request
// and in_stall rises once it is full.
`timescale 1ns / 1ps
module crt_controller_raster_timing_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [3:0]  in_port,
  input  logic [7:0]  in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic [3:0]  out_status,
  output logic [15:0] out_row_address,
  output logic [4:0]  out_scan_line,
  output logic [6:0]  out_row_count,
  output logic        out_display_enable,
  output logic        out_cursor_visible,
  output logic        out_line_half,
  output logic [9:0]  out_display_line
);
  import crtc_pkg::*;

  logic         s1_valid_r;
  action_t      s1_action_r;
  logic [3:0]   s1_port_r;
  logic [7:0]   s1_data_r;
  logic         advance;
  logic         commit;
  logic         in_take;

  timing_regs_t tregs;
  logic [7:0]   read_data;
  logic [3:0]   status_cur;
  raster_view_t view_nxt;

  logic         out_valid_r;
  logic [7:0]   out_rd_r;
  raster_view_t out_view_r;

  // Handshake: the result register frees up when empty or taken
  assign advance  = !out_valid_r || !out_stall;
  assign commit   = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= action_t'(in_action);
      s1_port_r   <= in_port;
      s1_data_r   <= in_data;
    end
  end

  crtc_regfile u_regfile (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (commit),
    .action     (s1_action_r),
    .port       (s1_port_r),
    .data       (s1_data_r),
    .status_cur (status_cur),
    .tregs      (tregs),
    .read_data  (read_data)
  );

  crtc_raster u_raster (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (commit && s1_action_r == ACT_TICK),
    .tregs      (tregs),
    .status_cur (status_cur),
    .view_nxt   (view_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_rd_r   <= read_data;
      out_view_r <= view_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_rd_r;
  assign out_status         = out_view_r.status;
  assign out_row_address    = out_view_r.row_address;
  assign out_scan_line      = out_view_r.scan_line;
  assign out_row_count      = out_view_r.row_count;
  assign out_display_enable = out_view_r.display_enable;
  assign out_cursor_visible = out_view_r.cursor_visible;
  assign out_line_half      = out_view_r.line_half;
  assign out_display_line   = out_view_r.display_line;

endmodule

>>> sv/crtc_checker.sv
// Port-level checks for the CRT controller raster timing unit, bound to the top.
// Depends on crtc_pkg.
`timescale 1ns / 1ps
module crtc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_status,
  input logic [15:0] out_row_address,
  input logic [9:0]  out_display_line
);
  import crtc_pkg::*;

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_address)
                               && $stable(out_status))
    else $error("stalled result changed");

  // Input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // Only display-off and vsync status bits exist; line counter stays wrapped
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status[2:1] == 2'b00 && out_display_line < 10'(LINE_WRAP))
    else $error("result field out of range");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind crt_controller_raster_timing_unit crtc_checker u_crtc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status       (out_status),
  .out_row_address  (out_row_address),
  .out_display_line (out_display_line)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for crt_controller_raster_timing_unit: port writes, port reads
// and half-line ticks go in, and every result is checked against a raster predictor.
// Depends on crtc_pkg and the RTL top level.
module tb_top;
  import crtc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  // Ports that are accepted and ignored, and two spare ones
  localparam logic [3:0] PORT_MODE     = 4'd8;
  localparam logic [3:0] PORT_COLOUR   = 4'd9;
  localparam logic [3:0] PORT_CONTROL  = 4'd14;
  localparam logic [3:0] PORT_SPARE_LO = 4'd0;
  localparam logic [3:0] PORT_SPARE_HI = 4'd15;

  localparam logic [REG_IDX_W-1:0] R_LAST   = 5'd17;
  localparam logic [REG_IDX_W-1:0] R_BEYOND = 5'd31;

  // Writable bits per register, in register order
  localparam logic [7:0] WRITABLE [NREGS] = '{
    8'hff, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h1f, 8'h7f, 8'h7f, 8'hf3,
    8'h1f, 8'h7f, 8'h1f, 8'h3f, 8'hff, 8'h3f, 8'hff, 8'hff, 8'hff
  };

  typedef struct packed {
    logic [7:0]   read_data;
    raster_view_t view;
  } crtc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = ACT_NONE;
  logic [3:0]  in_port = '0;
  logic [7:0]  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic [3:0]  out_status;
  logic [15:0] out_row_address;
  logic [4:0]  out_scan_line;
  logic [6:0]  out_row_count;
  logic        out_display_enable;
  logic        out_cursor_visible;
  logic        out_line_half;
  logic [9:0]  out_display_line;

  crt_controller_raster_timing_unit dut (.*);

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [7:0]           regs_shadow [NREGS];
  logic [REG_IDX_W-1:0] sel_idx;
  logic                 second_half_q, dbl_phase_q;
  logic [4:0]           scan_q, adjust_q, vsync_q, blink_q;
  logic [6:0]           row_q;
  logic [15:0]          addr_q, row_base_q;
  logic                 cursor_win_q, blink_on_q, disp_q;
  logic [3:0]           status_q;
  logic [9:0]           line_q;

  crtc_result_t expected_results [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int requests_sent = 0;
  int mismatches = 0;

  function automatic void clear_predictor();
    foreach (regs_shadow[i]) regs_shadow[i] = '0;
    sel_idx = '0;
    second_half_q = 1'b0;
    dbl_phase_q = 1'b0;
    {scan_q, adjust_q, vsync_q, blink_q, row_q} = '0;
    {addr_q, row_base_q} = '0;
    {cursor_win_q, blink_on_q, disp_q} = '0;
    status_q = '0;
    line_q = '0;
  endfunction

  function automatic logic [15:0] frame_start_addr();
    return {regs_shadow[R_START_HI], regs_shadow[R_START_LO]} & 16'h3fff;
  endfunction

  // Scanline compare; in double-scan mode half the value matches too
  function automatic logic scan_hits(input int v);
    logic dbl;
    dbl = (regs_shadow[R_MODE][1:0] == 2'b11);
    return (int'(scan_q) == v) || (dbl && int'(scan_q) == (v >> 1));
  endfunction

  function automatic void first_half_tick();
    int next_line;
    status_q[ST_DISP_OFF] = 1'b1;
    second_half_q = 1'b1;
    if (disp_q) addr_q = addr_q + {8'h00, regs_shadow[R_HDISP]};
    if (int'(row_q) == int'(regs_shadow[R_VSYNC_POS]) && scan_q == '0)
      status_q[ST_VSYNC] = 1'b1;
    next_line = int'(line_q) + 1;
    line_q = (next_line >= LINE_WRAP) ? 10'd0 : next_line[9:0];
  endfunction

  // Last scanline of a character row
  function automatic void close_row();
    logic [6:0] prev_row;
    prev_row = row_q;
    row_base_q = addr_q;
    scan_q = '0;
    row_q = row_q + 7'd1;
    if (int'(row_q) == int'(regs_shadow[R_VDISP])) disp_q = 1'b0;
    if (int'(prev_row) == int'(regs_shadow[R_VTOTAL])) begin
      row_q = '0;
      adjust_q = regs_shadow[R_VADJ][4:0];
      if (adjust_q == '0) begin
        disp_q = 1'b1;
        addr_q = frame_start_addr();
        row_base_q = addr_q;
      end
      if ((regs_shadow[R_CUR_START] & 8'h60) == 8'h20) blink_on_q = 1'b0;
      else blink_on_q = blink_q[4];
    end
    if (int'(row_q) == int'(regs_shadow[R_VSYNC_POS])) begin
      disp_q = 1'b0;
      line_q = '0;
      vsync_q = {1'b0, regs_shadow[R_SYNC_W][7:4]} + 5'd1;
      blink_q = blink_q + 5'd1;
    end
  endfunction

  function automatic void second_half_tick();
    if (disp_q) status_q[ST_DISP_OFF] = 1'b0;
    second_half_q = 1'b0;
    dbl_phase_q = ~dbl_phase_q;
    if (dbl_phase_q) begin
      addr_q = row_base_q;
      return;
    end
    if (vsync_q != '0) begin
      vsync_q = vsync_q - 5'd1;
      if (vsync_q == '0) status_q[ST_VSYNC] = 1'b0;
    end
    if (scan_hits(int'(regs_shadow[R_CUR_END][4:0]))) cursor_win_q = 1'b0;
    if (adjust_q != '0) begin
      scan_q = scan_q + 5'd1;
      addr_q = row_base_q;
      adjust_q = adjust_q - 5'd1;
      if (adjust_q == '0) begin
        disp_q = 1'b1;
        addr_q = frame_start_addr();
        row_base_q = addr_q;
        scan_q = '0;
      end
    end else if (scan_hits(int'(regs_shadow[R_MAXSCAN]))) begin
      close_row();
    end else begin
      scan_q = scan_q + 5'd1;
      addr_q = row_base_q;
    end
    if (scan_hits(int'(regs_shadow[R_CUR_START][4:0]))) cursor_win_q = 1'b1;
  endfunction

  // Apply one accepted request and return the result it should produce
  function automatic crtc_result_t predict_request(input action_t act,
                                                   input logic [3:0] req_port,
                                                   input logic [7:0] req_data);
    crtc_result_t r;
    r = '0;
    case (act)
      ACT_WRITE: begin
        if (req_port == PORT_INDEX) sel_idx = req_data[REG_IDX_W-1:0];
        else if (req_port == PORT_DATA && sel_idx < NREGS)
          regs_shadow[sel_idx] = req_data & WRITABLE[sel_idx];
      end
      ACT_READ: begin
        if (req_port == PORT_INDEX) r.read_data = {3'b000, sel_idx};
        else if (req_port == PORT_DATA)
          r.read_data = (sel_idx < NREGS) ? regs_shadow[sel_idx] : 8'h00;
        else if (req_port == PORT_STATUS) r.read_data = {4'h0, status_q};
        else r.read_data = 8'hff;
      end
      ACT_TICK: begin
        if (!second_half_q) first_half_tick();
        else second_half_tick();
      end
      default: ;
    endcase
    r.view.status         = status_q;
    r.view.row_address    = addr_q;
    r.view.scan_line      = scan_q;
    r.view.row_count      = row_q;
    r.view.display_enable = disp_q;
    r.view.cursor_visible = cursor_win_q & blink_on_q;
    r.view.line_half      = dbl_phase_q;
    r.view.display_line   = line_q;
    return r;
  endfunction

  function automatic string result_text(input crtc_result_t r);
    return $sformatf("rd=%h st=%h addr=%h scan=%0d row=%0d de=%b cur=%b half=%b line=%0d",
                     r.read_data, r.view.status, r.view.row_address, r.view.scan_line,
                     r.view.row_count, r.view.display_enable, r.view.cursor_visible,
                     r.view.line_half, r.view.display_line);
  endfunction

  // Result side: back-pressure, with a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    crtc_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.read_data           = out_read_data;
      got.view.status         = out_status;
      got.view.row_address    = out_row_address;
      got.view.scan_line      = out_scan_line;
      got.view.row_count      = out_row_count;
      got.view.display_enable = out_display_enable;
      got.view.cursor_visible = out_cursor_visible;
      got.view.line_half      = out_line_half;
      got.view.display_line   = out_display_line;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result with nothing pending: %s", result_text(got));
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t: expected %s", $realtime, result_text(want));
            $display("               actual   %s", result_text(got));
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("CHECKS FAILED");
    $finish;
  end

  // Offer one request, with a random gap first, and wait for it to be taken
  task automatic send_request(input action_t act, input logic [3:0] req_port,
                              input logic [7:0] req_data);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_port   <= req_port;
    in_data   <= req_data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(predict_request(act, req_port, req_data));
    requests_sent++;
  endtask

  task automatic stop_requests();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_for_results();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] r, input logic [7:0] v);
    send_request(ACT_WRITE, PORT_INDEX, {3'b000, r});
    send_request(ACT_WRITE, PORT_DATA, v);
  endtask

  // Small timing values keep frames short; wild picks any byte now and then
  function automatic logic [7:0] timing_value(input logic [REG_IDX_W-1:0] r,
                                              input logic wild);
    if (wild && $urandom_range(3) == 0) return 8'($urandom_range(255));
    case (r)
      R_VTOTAL, R_VDISP, R_VSYNC_POS: return 8'($urandom_range(4));
      R_VADJ, R_MAXSCAN, R_CUR_END:   return 8'($urandom_range(3));
      R_CUR_START: return {1'b0, 2'($urandom_range(3)), 5'($urandom_range(3))};
      default:     return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic program_random_timing();
    logic [REG_IDX_W-1:0] timing_regs [12];
    timing_regs = '{R_HDISP, R_SYNC_W, R_VTOTAL, R_VADJ, R_VDISP, R_VSYNC_POS,
                    R_MODE, R_MAXSCAN, R_CUR_START, R_CUR_END, R_START_HI, R_START_LO};
    foreach (timing_regs[i]) write_reg(timing_regs[i], timing_value(timing_regs[i], 1'b0));
  endtask

  // Reads straight after reset, and a request with the unused action code
  task automatic test_reset_state();
    send_request(ACT_READ, PORT_INDEX, 8'h00);
    send_request(ACT_READ, PORT_DATA, 8'h00);
    send_request(ACT_READ, PORT_STATUS, 8'h00);
    send_request(ACT_READ, PORT_SPARE_HI, 8'h00);
    send_request(ACT_NONE, PORT_DATA, 8'hff);
  endtask

  // Index beyond the register file, masked bits of mode, last register
  task automatic test_register_masks();
    write_reg(R_BEYOND, 8'hff);
    send_request(ACT_READ, PORT_DATA, 8'h00);
    write_reg(R_MODE, 8'hff);
    send_request(ACT_READ, PORT_DATA, 8'h00);
    write_reg(R_LAST, 8'hff);
    send_request(ACT_READ, PORT_DATA, 8'h00);
    send_request(ACT_READ, PORT_INDEX, 8'h00);
  endtask

  // Mode, colour and control writes, plus a spare port write and a mode port read
  task automatic test_ignored_ports();
    send_request(ACT_WRITE, PORT_MODE, 8'hff);
    send_request(ACT_WRITE, PORT_COLOUR, 8'hff);
    send_request(ACT_WRITE, PORT_CONTROL, 8'hff);
    send_request(ACT_WRITE, PORT_SPARE_LO, 8'hff);
    send_request(ACT_READ, PORT_MODE, 8'h00);
  endtask

  // A few half-lines in double-scan mode, then status
  task automatic test_first_ticks();
    repeat (6) send_request(ACT_TICK, PORT_SPARE_LO, 8'h00);
    send_request(ACT_READ, PORT_STATUS, 8'h00);
  endtask

  // Mostly ticks and register writes over short frames, with reads and noise
  task automatic test_random_traffic(input int count);
    int stop_at;
    int pick;
    logic [REG_IDX_W-1:0] r;
    logic [3:0] rd_port;
    stop_at = requests_sent + count;
    program_random_timing();
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_request(ACT_TICK, 4'($urandom_range(15)), 8'($urandom_range(255)));
      end else if (pick < 70) begin
        r = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(NREGS - 1));
        write_reg(r, timing_value(r, 1'b1));
      end else if (pick < 72) begin
        program_random_timing();
      end else if (pick < 88) begin
        case ($urandom_range(3))
          0:       rd_port = PORT_INDEX;
          1:       rd_port = PORT_DATA;
          2:       rd_port = PORT_STATUS;
          default: rd_port = 4'($urandom_range(15));
        endcase
        send_request(ACT_READ, rd_port, 8'($urandom_range(255)));
      end else begin
        send_request(action_t'($urandom_range(3)), 4'($urandom_range(15)),
                     8'($urandom_range(255)));
      end
    end
  endtask

  // Result side holds off while requests keep coming, then a full drain
  task automatic test_backpressure();
    hold_cycles = 60;
    repeat (30) send_request(ACT_TICK, PORT_SPARE_LO, 8'h00);
    stop_requests();
    wait_for_results();
  endtask

  initial begin
    clear_predictor();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_register_masks();
    test_ignored_ports();
    test_first_ticks();

    send_idle_pct = 20;
    recv_idle_pct = 86;
    test_random_traffic(350);

    send_idle_pct = 86;
    recv_idle_pct = 20;
    test_random_traffic(350);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_traffic(340);

    stop_requests();
    wait_for_results();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      $display("%0d results never arrived", expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
